@@ sv/pid_controller_step_macros.svh @@
// assertion macros for the pid controller step block
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// same-cycle implication
`define PIDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pidc: same-cycle check failed");

// next-cycle implication
`define PIDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pidc: next-cycle check failed");

`endif

@@ sv/pidc_pkg.sv @@
// pidc_pkg: widths, divider request/response types and the control program
// used by pidc_divider and pid_controller_step; no dependencies
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int SUM_WIDTH      = 32;

    localparam int GAIN_W  = 16;
    localparam int PER_W   = 8;
    localparam int IN_W    = 16;
    localparam int ERR_W   = IN_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DRIVE_W = 32;

    localparam int MUL_A_W = (SUM_WIDTH > DIFF_W) ? SUM_WIDTH : DIFF_W;
    localparam int MUL_B_W = ((GAIN_W > PER_W + 1) ? GAIN_W : PER_W + 1) + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;

    localparam int DIV_CNT_W = $clog2(DIFF_W + 1);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INTEG_GAIN    = 2'd1,
        CFG_DERIV_GAIN    = 2'd2,
        CFG_SAMPLE_PERIOD = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] dividend;
        logic        [PER_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic signed [DIFF_W-1:0] quotient;
    } div_rsp_t;

    // multiplier operand pairs
    typedef enum logic [1:0] {
        MUL_ERR_PER = 2'd0,
        MUL_KP_ERR  = 2'd1,
        MUL_KI_INT  = 2'd2,
        MUL_KD_QUO  = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_add;
        logic     integ_upd;
        logic     div_start;
        logic     wait_div;
        logic     out_step;
    } ucode_t;

    localparam int STEP_W = 3;

    typedef enum logic [STEP_W-1:0] {
        ST_ERR_PER  = 3'd0,
        ST_INTEG    = 3'd1,
        ST_P_TERM   = 3'd2,
        ST_I_TERM   = 3'd3,
        ST_WAIT_DIV = 3'd4,
        ST_D_MUL    = 3'd5,
        ST_D_TERM   = 3'd6,
        ST_OUT      = 3'd7
    } step_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t cw;
        cw = '0;
        cw.mul_sel = MUL_ERR_PER;
        unique case (step)
            ST_ERR_PER: begin
                cw.mul_en    = 1'b1;
                cw.mul_sel   = MUL_ERR_PER;
                cw.acc_clr   = 1'b1;
                cw.div_start = 1'b1;
            end
            ST_INTEG: begin
                cw.integ_upd = 1'b1;
                cw.mul_en    = 1'b1;
                cw.mul_sel   = MUL_KP_ERR;
            end
            ST_P_TERM: begin
                cw.acc_add = 1'b1;
                cw.mul_en  = 1'b1;
                cw.mul_sel = MUL_KI_INT;
            end
            ST_I_TERM: begin
                cw.acc_add = 1'b1;
            end
            ST_WAIT_DIV: begin
                cw.wait_div = 1'b1;
            end
            ST_D_MUL: begin
                cw.mul_en  = 1'b1;
                cw.mul_sel = MUL_KD_QUO;
            end
            ST_D_TERM: begin
                cw.acc_add = 1'b1;
            end
            ST_OUT: begin
                cw.out_step = 1'b1;
            end
            default: begin
                cw.out_step = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

@@ sv/pidc_divider.sv @@
// pidc_divider: serial restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle; uses pidc_pkg
`timescale 1ns / 1ps

module pidc_divider
    import pidc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIFF_W-1:0]    quo_reg, quo_next;
    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [PER_W-1:0]     dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;

    logic [PER_W:0]       rem_shift;
    logic [PER_W:0]       rem_trial;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIFF_W-1]};
        rem_trial = rem_shift - {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIFF_W);
            rem_next  = '0;
            dvs_next  = req.divisor;
            neg_next  = req.dividend[DIFF_W-1];
            quo_next  = req.dividend[DIFF_W-1] ? DIFF_W'(-req.dividend)
                                               : DIFF_W'(req.dividend);
        end else if (busy_reg) begin
            if (!rem_trial[PER_W]) begin
                rem_next = rem_trial[PER_W-1:0];
                quo_next = {quo_reg[DIFF_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[PER_W-1:0];
                quo_next = {quo_reg[DIFF_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);

endmodule

@@ sv/pid_controller_step.sv @@
// pid_controller_step: positional pid controller, microcoded over one shared
// multiplier and accumulator; uses pidc_pkg, pidc_divider and the macro header
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_setpoint, s_measured
//   m_       out  m_valid/m_ready    m_drive, m_clipped
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// one transaction runs from acceptance to the result register, and the next one
// is accepted only once that result is loaded, so transactions do not overlap;
// the serial divider for the derivative term takes most of that time, the rest
// is the eight-step control program sharing one 32x18 multiplier.
// s_ready is high whenever no transaction is in the program.
// a result waiting in the output register stalls only the last step.
// aresetn is synchronous; gains reset to zero, sample period to one.
`timescale 1ns / 1ps
`include "pid_controller_step_macros.svh"

module pid_controller_step
    import pidc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [IN_W-1:0]    s_setpoint,
    input  logic signed [IN_W-1:0]    s_measured,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive,
    output logic                      m_clipped,

    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [GAIN_W-1:0]         cfg_wdata
);

    // configuration
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic        [PER_W-1:0]  per_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            kd_reg  <= '0;
            per_reg <= PER_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PROP_GAIN:     kp_reg  <= cfg_wdata;
                CFG_INTEG_GAIN:    ki_reg  <= cfg_wdata;
                CFG_DERIV_GAIN:    kd_reg  <= cfg_wdata;
                CFG_SAMPLE_PERIOD: per_reg <= cfg_wdata[PER_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    logic   busy_reg, busy_next;
    step_t  step_reg, step_next;
    ucode_t cw;
    logic   accept;
    logic   out_free;
    logic   out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign accept   = s_valid && s_ready;
    assign s_ready  = !busy_reg;
    assign cw       = ucode_rom(step_reg);
    assign out_free = !m_valid || m_ready;
    assign out_load = busy_reg && cw.out_step && out_free;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept) begin
            busy_next = 1'b1;
            step_next = ST_ERR_PER;
        end else if (busy_reg) begin
            if (cw.out_step) begin
                if (out_free) begin
                    busy_next = 1'b0;
                end
            end else if (!(cw.wait_div && div_rsp.busy)) begin
                step_next = step_t'(step_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= ST_ERR_PER;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // datapath
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [ERR_W-1:0]     prev_err_reg;
    logic signed [SUM_WIDTH-1:0] integ_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        clip_reg;

    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [SUM_WIDTH+1:0]   isum;
    logic                          isum_ovf;
    logic signed [SUM_WIDTH-1:0]   isum_sat;
    logic signed [ACC_W-1:0]       shifted;
    logic                          drv_ovf;
    logic signed [DRIVE_W-1:0]     drv_sat;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cw.mul_sel)
            MUL_ERR_PER: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed({{(MUL_B_W-PER_W){1'b0}}, per_reg});
            end
            MUL_KP_ERR: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(kp_reg);
            end
            MUL_KI_INT: begin
                mul_a = MUL_A_W'(integ_reg);
                mul_b = MUL_B_W'(ki_reg);
            end
            MUL_KD_QUO: begin
                mul_a = MUL_A_W'(div_rsp.quotient);
                mul_b = MUL_B_W'(kd_reg);
            end
            default: ;
        endcase
    end

    // integral clamp
    always_comb begin
        isum     = (SUM_WIDTH+2)'(integ_reg) + $signed(prod_reg[SUM_WIDTH+1:0]);
        isum_ovf = (isum[SUM_WIDTH+1:SUM_WIDTH-1] != '0)
                && (isum[SUM_WIDTH+1:SUM_WIDTH-1] != '1);
        if (!isum_ovf) begin
            isum_sat = isum[SUM_WIDTH-1:0];
        end else if (isum[SUM_WIDTH+1]) begin
            isum_sat = {1'b1, {(SUM_WIDTH-1){1'b0}}};
        end else begin
            isum_sat = {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
    end

    // drive: floor shift then clamp
    always_comb begin
        shifted = acc_reg >>> GAIN_FRAC_BITS;
        drv_ovf = (shifted[ACC_W-1:DRIVE_W-1] != '0)
               && (shifted[ACC_W-1:DRIVE_W-1] != '1);
        if (!drv_ovf) begin
            drv_sat = shifted[DRIVE_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            drv_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            drv_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    assign div_req.start    = busy_reg && cw.div_start;
    assign div_req.dividend = DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
    assign div_req.divisor  = (per_reg == '0) ? PER_W'(1) : per_reg;

    pidc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            if (busy_reg && cw.integ_upd) begin
                integ_reg <= isum_sat;
            end
            if (out_load) begin
                prev_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err_reg  <= ERR_W'(s_setpoint) - ERR_W'(s_measured);
            clip_reg <= 1'b0;
        end else if (busy_reg && cw.integ_upd && isum_ovf) begin
            clip_reg <= 1'b1;
        end
        if (busy_reg && cw.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (busy_reg && cw.acc_clr) begin
            acc_reg <= '0;
        end else if (busy_reg && cw.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_drive   <= drv_sat;
            m_clipped <= clip_reg || drv_ovf;
        end
    end

    assign m_valid = m_valid_reg;

    `PIDC_ASSERT_NEXT(a_start_step, accept, busy_reg && step_reg == ST_ERR_PER)
    `PIDC_ASSERT_SAME(a_div_idle, !busy_reg, !div_rsp.busy)
    `PIDC_ASSERT_NEXT(a_wait_hold, busy_reg && cw.wait_div && div_rsp.busy, step_reg == ST_WAIT_DIV)
    `PIDC_ASSERT_NEXT(a_out_done, out_load, !busy_reg && m_valid)

endmodule
